// ===== design/erw_pkg.sv =====
// shared types and constants for the container record walker
// no dependencies
`default_nettype none
package erw_pkg;

   localparam int MAX_RECORDS      = 256;
   localparam int MAX_PAYLOAD      = 16777216;
   localparam int KIND_TEXT_BUFFER = 80;
   localparam int PATH_TEXT_BUFFER = 160;

   localparam logic [31:0] KS_MULT    = 32'h0001_3AE9;
   localparam logic [31:0] TAG_SEED   = 32'h0000_18EE;
   localparam logic [31:0] TAG_FILE   = 32'h454C_4946;
   localparam logic [31:0] KLEN_MASK  = 32'h0000_ADBC;
   localparam logic [31:0] KLEN_MAX   = 32'h0001_0000;
   localparam logic [31:0] KIND_SEED  = 32'h0000_B33F;
   localparam logic [31:0] PLEN_MASK  = 32'h0000_F820;
   localparam logic [31:0] PLEN_MAX   = 32'h0000_4000;
   localparam logic [31:0] PATH_SEED  = 32'h0000_F479;
   localparam logic [31:0] SIZE_MASK  = 32'h0000_87BC;

   localparam logic [1:0] RK_KIND_CHAR = 2'd0;
   localparam logic [1:0] RK_PATH_CHAR = 2'd1;
   localparam logic [1:0] RK_RECORD    = 2'd2;
   localparam logic [1:0] RK_DONE      = 2'd3;

   localparam logic [2:0] STOP_CLEAN     = 3'd0;
   localparam logic [2:0] STOP_LIMIT     = 3'd1;
   localparam logic [2:0] STOP_BAD_TAG   = 3'd2;
   localparam logic [2:0] STOP_OVER      = 3'd3;
   localparam logic [2:0] STOP_TRUNCATED = 3'd4;
   localparam logic [2:0] STOP_SHORT     = 3'd5;

   typedef enum logic [3:0] {
      PH_SKIP, PH_TAG, PH_SLEN, PH_KIND, PH_PLEN, PH_PATH,
      PH_CFLAG, PH_CSIZE, PH_USIZE, PH_DATA, PH_HALT
   } phase_type;

   typedef struct packed {
      logic        first_byte;
      logic [7:0]  data_byte;
      logic [24:0] body_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [6:0]  text_char;
      logic        is_compressed;
      logic [24:0] payload_offset;
      logic [24:0] stored_size;
      logic [31:0] original_size;
      logic [8:0]  record_count;
      logic [2:0]  stop_reason;
      logic        walk_ok;
      logic        last_of_item;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/erw_front.sv =====
// byte parser: decrypts, walks record fields and forms up to two results a beat
// depends on erw_pkg
`default_nettype none
module erw_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire erw_pkg::req_type in_data,
   output logic [1:0]            wr_count,
   output erw_pkg::rsp_type      wr_res0,
   output erw_pkg::rsp_type      wr_res1
);
   import erw_pkg::*;

   phase_type   phase_ff, phase_in, phase_cur;
   logic [24:0] pos_ff, pos_in, pos_cur;
   logic [1:0]  cnt_ff, cnt_in, cnt_cur;
   logic [31:0] key_ff, key_in, key_cur;
   logic [31:0] word_ff, word_in, word_cur;
   logic [17:0] sbl_ff, sbl_in, sbl_cur;
   logic [7:0]  chars_ff, chars_in, chars_cur;
   logic        ended_ff, ended_in, ended_cur;
   logic [7:0]  low_ff, low_in, low_cur;
   logic [8:0]  rec_ff, rec_in, rec_cur;
   logic        flag_ff, flag_in, flag_cur;
   logic [24:0] cs_ff, cs_in, cs_cur;
   logic [24:0] pbl_ff, pbl_in, pbl_cur;

   logic [25:0] nxt;
   logic [24:0] n;
   logic [7:0]  b, kb;
   logic [31:0] key_mul, gw, len, sz;
   logic        gdone;
   logic [15:0] c;
   logic [8:0]  cap;
   logic        do_head, do_ak, do_ap, do_fin;
   logic [2:0]  why;
   logic        char_v, sec_v;
   rsp_type     char_r, sec_r;

   always_comb begin
      phase_cur = in_data.first_byte ? PH_SKIP : phase_ff;
      pos_cur   = in_data.first_byte ? '0 : pos_ff;
      cnt_cur   = in_data.first_byte ? '0 : cnt_ff;
      key_cur   = in_data.first_byte ? '0 : key_ff;
      word_cur  = in_data.first_byte ? '0 : word_ff;
      sbl_cur   = in_data.first_byte ? '0 : sbl_ff;
      chars_cur = in_data.first_byte ? '0 : chars_ff;
      ended_cur = in_data.first_byte ? 1'b0 : ended_ff;
      low_cur   = in_data.first_byte ? '0 : low_ff;
      rec_cur   = in_data.first_byte ? '0 : rec_ff;
      flag_cur  = in_data.first_byte ? 1'b0 : flag_ff;
      cs_cur    = in_data.first_byte ? '0 : cs_ff;
      pbl_cur   = in_data.first_byte ? '0 : pbl_ff;

      phase_in = phase_cur; pos_in = pos_cur; cnt_in = cnt_cur; key_in = key_cur;
      word_in = word_cur; sbl_in = sbl_cur; chars_in = chars_cur;
      ended_in = ended_cur; low_in = low_cur; rec_in = rec_cur;
      flag_in = flag_cur; cs_in = cs_cur; pbl_in = pbl_cur;

      n   = in_data.body_length;
      b   = in_data.data_byte;
      nxt = {1'b0, pos_cur} + 26'd1;
      key_mul = key_cur * KS_MULT;
      kb  = b ^ key_mul[15:8];
      gw  = word_cur | ({24'b0, b} << {cnt_cur, 3'b000});
      gdone = (cnt_cur == 2'd3);
      len = '0;
      sz  = '0;
      c   = '0;
      cap = (phase_cur == PH_PATH) ? 9'(PATH_TEXT_BUFFER) : 9'(KIND_TEXT_BUFFER);
      do_head = 1'b0; do_ak = 1'b0; do_ap = 1'b0; do_fin = 1'b0;
      why = STOP_CLEAN;
      char_v = 1'b0; sec_v = 1'b0;
      char_r = '0; sec_r = '0;

      if (phase_cur != PH_HALT) begin
         pos_in = nxt[24:0];
      end

      case (phase_cur)
         PH_SKIP: begin
            if (pos_cur == '0 && n < 25'd24) begin
               do_fin = 1'b1; why = STOP_SHORT;
            end else if (pos_cur >= 25'd15) begin
               do_head = 1'b1;
            end
         end
         PH_TAG: begin
            key_in  = key_mul;
            word_in = word_cur | ({24'b0, kb} << {cnt_cur, 3'b000});
            cnt_in  = cnt_cur + 2'd1;
            if (gdone) begin
               if (word_in != TAG_FILE) begin
                  do_fin = 1'b1; why = STOP_BAD_TAG;
               end else begin
                  phase_in = PH_SLEN; cnt_in = '0; word_in = '0;
               end
            end
         end
         PH_SLEN, PH_PLEN: begin
            word_in = gw;
            cnt_in  = cnt_cur + 2'd1;
            if (gdone) begin
               len = gw ^ ((phase_cur == PH_SLEN) ? KLEN_MASK : PLEN_MASK);
               if (len > ((phase_cur == PH_SLEN) ? KLEN_MAX : PLEN_MAX)) begin
                  do_fin = 1'b1; why = STOP_OVER;
               end else if ({1'b0, nxt} + {8'b0, len[17:0], 1'b0} > {2'b0, n}) begin
                  do_fin = 1'b1; why = STOP_TRUNCATED;
               end else if (len == '0) begin
                  if (phase_cur == PH_SLEN) do_ak = 1'b1;
                  else do_ap = 1'b1;
               end else begin
                  phase_in = (phase_cur == PH_SLEN) ? PH_KIND : PH_PATH;
                  key_in   = len + ((phase_cur == PH_SLEN) ? KIND_SEED : PATH_SEED);
                  sbl_in   = {len[16:0], 1'b0};
                  chars_in = '0;
                  ended_in = 1'b0;
                  cnt_in   = '0;
               end
            end
         end
         PH_KIND, PH_PATH: begin
            key_in = key_mul;
            sbl_in = (sbl_cur != '0) ? sbl_cur - 18'd1 : '0;
            if (cnt_cur == '0) begin
               low_in = kb;
               cnt_in = 2'd1;
            end else begin
               cnt_in = '0;
               if (!ended_cur) begin
                  c = {kb, low_cur};
                  if (c == '0) begin
                     ended_in = 1'b1;
                  end else begin
                     char_v = 1'b1;
                     char_r.result_kind = (phase_cur == PH_PATH) ? RK_PATH_CHAR
                                                                 : RK_KIND_CHAR;
                     if ((c >= 16'd32 && c <= 16'd126) || c == 16'd9 || c == 16'd10
                         || c == 16'd13)
                        char_r.text_char = c[6:0];
                     else
                        char_r.text_char = 7'd63;
                     chars_in = chars_cur + 8'd1;
                     if ({1'b0, chars_cur} + 9'd1 >= cap - 9'd1) ended_in = 1'b1;
                  end
               end
            end
            if (sbl_in == '0) begin
               if (phase_cur == PH_KIND) do_ak = 1'b1;
               else do_ap = 1'b1;
            end
         end
         PH_CFLAG: begin
            flag_in = (b != 8'd0);
            cs_in = '0;
            phase_in = PH_CSIZE; cnt_in = '0; word_in = '0;
         end
         PH_CSIZE: begin
            word_in = gw;
            cnt_in  = cnt_cur + 2'd1;
            if (gdone) begin
               sz = gw ^ SIZE_MASK;
               cs_in = (sz[31:25] != '0) ? '1 : sz[24:0];
               phase_in = PH_USIZE; cnt_in = '0; word_in = '0;
            end
         end
         PH_USIZE: begin
            word_in = gw;
            cnt_in  = cnt_cur + 2'd1;
            if (gdone) begin
               if ({7'b0, cs_cur} > 32'(MAX_PAYLOAD)) begin
                  do_fin = 1'b1; why = STOP_OVER;
               end else if ({1'b0, nxt} + 27'd20 + {2'b0, cs_cur} > {2'b0, n}) begin
                  do_fin = 1'b1; why = STOP_TRUNCATED;
               end else begin
                  sec_v = 1'b1;
                  sec_r.result_kind    = RK_RECORD;
                  sec_r.is_compressed  = flag_cur;
                  sec_r.payload_offset = nxt[24:0] + 25'd20;
                  sec_r.stored_size    = cs_cur;
                  sec_r.original_size  = gw ^ SIZE_MASK;
                  rec_in   = rec_cur + 9'd1;
                  pbl_in   = cs_cur + 25'd20;
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            pbl_in = (pbl_cur != '0) ? pbl_cur - 25'd1 : '0;
            if (pbl_in == '0) do_head = 1'b1;
         end
         PH_HALT: begin
         end
         default: phase_in = PH_HALT;
      endcase

      if (do_head) begin
         if ({1'b0, nxt} + 27'd8 >= {2'b0, n}) begin
            do_fin = 1'b1; why = STOP_CLEAN;
         end else if (rec_cur >= 9'(MAX_RECORDS)) begin
            do_fin = 1'b1; why = STOP_LIMIT;
         end else begin
            phase_in = PH_TAG; key_in = TAG_SEED; cnt_in = '0; word_in = '0;
         end
      end
      if (do_ak) begin
         if ({1'b0, nxt} + 27'd4 > {2'b0, n}) begin
            do_fin = 1'b1; why = STOP_TRUNCATED;
         end else begin
            phase_in = PH_PLEN; cnt_in = '0; word_in = '0;
         end
      end
      if (do_ap) begin
         if ({1'b0, nxt} + 27'd13 > {2'b0, n}) begin
            do_fin = 1'b1; why = STOP_TRUNCATED;
         end else begin
            phase_in = PH_CFLAG;
         end
      end
      if (do_fin) begin
         phase_in = PH_HALT;
         sec_v = 1'b1;
         sec_r = '0;
         sec_r.result_kind  = RK_DONE;
         sec_r.record_count = rec_cur;
         sec_r.stop_reason  = why;
         sec_r.walk_ok      = (rec_cur != '0);
      end

      // char comes first when a beat makes two results
      char_r.last_of_item = !sec_v;
      sec_r.last_of_item  = 1'b1;
      wr_res0 = char_v ? char_r : sec_r;
      wr_res1 = sec_r;
      if (!in_valid) wr_count = 2'd0;
      else wr_count = {1'b0, char_v} + {1'b0, sec_v};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         pos_ff <= '0; cnt_ff <= '0; key_ff <= '0; word_ff <= '0;
         sbl_ff <= '0; chars_ff <= '0; ended_ff <= 1'b0; low_ff <= '0;
         rec_ff <= '0; flag_ff <= 1'b0; cs_ff <= '0; pbl_ff <= '0;
      end else if (in_valid) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in; cnt_ff <= cnt_in; key_ff <= key_in; word_ff <= word_in;
         sbl_ff <= sbl_in; chars_ff <= chars_in; ended_ff <= ended_in; low_ff <= low_in;
         rec_ff <= rec_in; flag_ff <= flag_in; cs_ff <= cs_in; pbl_ff <= pbl_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/erw_queue.sv =====
// four-entry result queue, takes up to two results a cycle and hands out one
// depends on erw_pkg
`default_nettype none
module erw_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       wr_count,
   input  wire erw_pkg::rsp_type wr_res0,
   input  wire erw_pkg::rsp_type wr_res1,
   output logic                  full,
   output logic                  empty,
   input  wire logic             pop,
   output erw_pkg::rsp_type      rd_res
);
   import erw_pkg::*;

   rsp_type     mem_ff [4];
   logic [1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;
   logic        do_pop;

   assign empty  = (count_ff == 3'd0);
   // room for two results is kept so a beat never stalls mid-item
   assign full   = (count_ff >= 3'd3);
   assign rd_res = mem_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + wr_count;
      rd_ptr_in = rd_ptr_ff + {1'b0, do_pop};
      count_in  = count_ff + {1'b0, wr_count} - {2'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) mem_ff[wr_ptr_ff] <= wr_res0;
      if (wr_count == 2'd2) mem_ff[wr_ptr_ff + 2'd1] <= wr_res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/encrypted_record_container_walker.sv =====
// top level: byte parser front feeding a result queue back end
// depends on erw_pkg, erw_front, erw_queue
//
//   channel   ports                       handshake
//   req       req_push req_full req_data   accepted on push && !full
//   rsp       rsp_pop rsp_empty rsp_data   accepted on pop && !empty
//
// one body byte is taken every cycle while not full; parser finishes it that cycle
// a byte makes zero, one or two results; they wait in a four-entry queue
// full rises only while three or more results wait unread
// reset is synchronous and restarts the walk; first_byte also restarts it
`default_nettype none
module encrypted_record_container_walker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire erw_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output erw_pkg::rsp_type      rsp_data
);
   import erw_pkg::*;

   logic       beat_in;
   logic [1:0] wr_count;
   rsp_type    wr_res0, wr_res1;

   assign beat_in = req_push && !req_full;

   erw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (beat_in),
      .in_data  (req_data),
      .wr_count (wr_count),
      .wr_res0  (wr_res0),
      .wr_res1  (wr_res1)
   );

   erw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_count (wr_count),
      .wr_res0  (wr_res0),
      .wr_res1  (wr_res1),
      .full     (req_full),
      .empty    (rsp_empty),
      .pop      (rsp_pop),
      .rd_res   (rsp_data)
   );
endmodule
`default_nettype wire
